// ===== design/ccte_pkg.sv =====
// shared types and constants of the cheat code table engine
package ccte_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);

  localparam logic [7:0] TYPE_PLAIN     = 8'h01;
  localparam logic [7:0] TYPE_WRAM_MASK = 8'h90;
  localparam logic [7:0] TYPE_RAM_MASK  = 8'h80;

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_ENABLE  = 3'd2,
    OP_DISABLE = 3'd3,
    OP_VBLANK  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    KIND_STATUS    = 2'd0,
    KIND_WRITE     = 2'd1,
    KIND_RAM_BANK  = 2'd2,
    KIND_WRAM_BANK = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CT_WRITE = 2'd0,
    CT_RAM   = 2'd1,
    CT_WRAM  = 2'd2
  } ctype_e;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] addr;
    logic [7:0]  value;
    logic [3:0]  bank;
    ctype_e      ctype;
    logic        enabled;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic ring;
    logic tail;
  } cell_ctrl_t;

endpackage

// ===== design/cheat_code_table_engine_top.sv =====
// top level of the cheat code table engine: control, ring of cells, result register
//
// channel  | handshake                | payload
// ---------+--------------------------+---------------------------------------------
// input    | in_valid_i / in_ready_o  | op_i, code_chars_i, entry_id_i
// result   | out_valid_o / out_ready_i| out_kind_o, out_addr_o, out_value_o,
//          |                          | out_bank_o, out_id_o, ok_o, last_o
//
// remove, enable and disable rotate the live entries once through the ring, one
// entry per cycle, after the transfer cycle and before the status cycle.
// vblank emits a bank change ahead of the write of each enabled ram or wram entry.
// reset empties the table; table slots hold no reset value.
// a stalled result register holds the walk in place until the transfer.
module cheat_code_table_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  op_i,
  input  logic [63:0] code_chars_i,
  input  logic [31:0] entry_id_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_kind_o,
  output logic [15:0] out_addr_o,
  output logic [7:0]  out_value_o,
  output logic [3:0]  out_bank_o,
  output logic [31:0] out_id_o,
  output logic        ok_o,
  output logic        last_o
);
  import ccte_pkg::*;

  state_e state_q, state_d;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] step_q, step_d;
  logic [CNT_W-1:0] len_q, len_d;
  op_e              op_q, op_d;
  logic [31:0]      id_q, id_d;
  logic             found_q, found_d;
  logic             phase_q, phase_d;

  logic        out_valid_q;
  kind_e       kind_q;
  logic [15:0] addr_q;
  logic [7:0]  value_q;
  logic [3:0]  bank_q;
  logic [31:0] oid_q;
  logic        ok_q;
  logic        last_q;

  entry_t dec_entry;
  logic   dec_valid;
  entry_t cells [ENTRIES];
  entry_t head;
  entry_t feed;

  logic        out_free;
  logic        in_fire;
  logic        emit;
  kind_e       e_kind;
  logic [15:0] e_addr;
  logic [7:0]  e_value;
  logic [3:0]  e_bank;
  logic [31:0] e_id;
  logic        e_ok;
  logic        e_last;
  logic        shift;
  logic        add_load;
  logic        start_walk;
  logic        walk_done;
  logic        match;

  ccte_decode u_decode (
    .code_chars_i (code_chars_i),
    .entry_o      (dec_entry),
    .valid_o      (dec_valid)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign in_fire  = in_valid_i && out_free && (state_q == ST_IDLE);
  assign head     = cells[0];

  // first matching entry only
  assign match = !found_q && (head.id == id_q);

  always_comb begin
    feed = head;
    if (match && op_q == OP_ENABLE) feed.enabled = 1'b1;
    if (match && op_q == OP_DISABLE) feed.enabled = 1'b0;
  end

  // control outputs
  always_comb begin
    in_ready_o = 1'b0;
    emit       = 1'b0;
    e_kind     = KIND_STATUS;
    e_addr     = '0;
    e_value    = '0;
    e_bank     = '0;
    e_id       = '0;
    e_ok       = 1'b0;
    e_last     = 1'b0;
    shift      = 1'b0;
    add_load   = 1'b0;
    start_walk = 1'b0;
    walk_done  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = out_free;
        if (in_fire) begin
          unique case (op_i)
            OP_ADD: begin
              add_load = dec_valid && (count_q < CNT_W'(ENTRIES));
              emit     = 1'b1;
              e_ok     = add_load;
              e_id     = add_load ? dec_entry.id : '0;
              e_last   = 1'b1;
            end
            OP_REMOVE, OP_ENABLE, OP_DISABLE, OP_VBLANK: begin
              start_walk = 1'b1;
            end
            default: begin
              emit   = 1'b1;
              e_last = 1'b1;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (step_q == len_q) begin
          emit      = 1'b1;
          e_ok      = (op_q == OP_VBLANK) ? 1'b1 : found_q;
          e_last    = 1'b1;
          walk_done = out_free;
        end else if (op_q == OP_VBLANK) begin
          if (head.enabled) begin
            emit = 1'b1;
            e_ok = 1'b1;
            if (head.ctype != CT_WRITE && !phase_q) begin
              e_kind = (head.ctype == CT_WRAM) ? KIND_WRAM_BANK : KIND_RAM_BANK;
              e_bank = head.bank;
            end else begin
              e_kind  = KIND_WRITE;
              e_addr  = head.addr;
              e_value = head.value;
              shift   = out_free;
            end
          end else begin
            shift = 1'b1;
          end
        end else begin
          shift = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_walk) state_d = ST_WALK;
      ST_WALK: if (walk_done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    count_d = count_q;
    step_d  = step_q;
    len_d   = len_q;
    op_d    = op_q;
    id_d    = id_q;
    found_d = found_q;
    phase_d = phase_q;
    if (start_walk) begin
      op_d    = op_e'(op_i);
      id_d    = entry_id_i;
      len_d   = count_q;
      step_d  = '0;
      found_d = 1'b0;
      phase_d = 1'b0;
    end
    if (add_load) count_d = count_q + 1'b1;
    if (state_q == ST_WALK && op_q == OP_VBLANK && emit && out_free && !shift
        && !e_last) begin
      phase_d = 1'b1;
    end
    if (shift) begin
      step_d  = step_q + 1'b1;
      phase_d = 1'b0;
      if (op_q != OP_VBLANK && match) begin
        found_d = 1'b1;
        // a removed entry drops out of the ring, the rest move up
        if (op_q == OP_REMOVE) count_d = count_q - 1'b1;
      end
    end
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    cell_ctrl_t ctrl;
    entry_t     nbr;

    assign ctrl.shift = shift;
    assign ctrl.load  = add_load && (CNT_W'(i) == count_q);
    assign ctrl.ring  = CNT_W'(i) < count_q;
    assign ctrl.tail  = CNT_W'(i + 1) == count_q;

    if (i == ENTRIES - 1) begin : g_end
      assign nbr = feed;
    end else begin : g_mid
      assign nbr = cells[i + 1];
    end

    ccte_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .nbr_i       (nbr),
      .feed_i      (feed),
      .load_data_i (dec_entry),
      .entry_o     (cells[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      len_q       <= '0;
      op_q        <= OP_ADD;
      found_q     <= 1'b0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      step_q  <= step_d;
      len_q   <= len_d;
      op_q    <= op_d;
      found_q <= found_d;
      phase_q <= phase_d;
      if (emit && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
    if (emit && out_free) begin
      kind_q  <= e_kind;
      addr_q  <= e_addr;
      value_q <= e_value;
      bank_q  <= e_bank;
      oid_q   <= e_id;
      ok_q    <= e_ok;
      last_q  <= e_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = kind_q;
  assign out_addr_o  = addr_q;
  assign out_value_o = value_q;
  assign out_bank_o  = bank_q;
  assign out_id_o    = oid_q;
  assign ok_o        = ok_q;
  assign last_o      = last_q;

endmodule

// ===== design/ccte_decode.sv =====
// ascii hex decoder that turns eight code characters into a table entry
module ccte_decode (
  input  logic [63:0]     code_chars_i,
  output ccte_pkg::entry_t entry_o,
  output logic            valid_o
);
  import ccte_pkg::*;

  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h10;
    if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
    else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
    else if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    return v[4:0];
  endfunction

  logic [3:0] d [8];
  logic [7:0] bad;
  logic [7:0] code_type;
  logic       type_ok;
  ctype_e     ctype;

  always_comb begin
    logic [4:0] n;
    for (int k = 0; k < 8; k++) begin
      n      = nibble_of(code_chars_i[8*k +: 8]);
      bad[k] = n[4];
      d[k]   = n[3:0];
    end
  end

  assign code_type = {d[0], d[1]};

  // wram codes are tested ahead of ram codes
  always_comb begin
    type_ok = 1'b1;
    ctype   = CT_WRITE;
    priority if (code_type == TYPE_PLAIN) begin
      ctype = CT_WRITE;
    end else if ((code_type & TYPE_WRAM_MASK) == TYPE_WRAM_MASK) begin
      ctype = CT_WRAM;
    end else if ((code_type & TYPE_RAM_MASK) == TYPE_RAM_MASK) begin
      ctype = CT_RAM;
    end else begin
      type_ok = 1'b0;
    end
  end

  assign valid_o = ~|bad && type_ok;

  always_comb begin
    entry_o.id      = {d[7], d[6], d[5], d[4], d[3], d[2], d[1], d[0]};
    entry_o.addr    = {d[6], d[7], d[4], d[5]};
    entry_o.value   = {d[2], d[3]};
    entry_o.bank    = d[1];
    entry_o.ctype   = ctype;
    entry_o.enabled = 1'b1;
  end

endmodule

// ===== design/ccte_cell.sv =====
// one table slot: loads a new entry or takes the entry handed down the ring
module ccte_cell (
  input  logic                 clk_i,
  input  ccte_pkg::cell_ctrl_t ctrl_i,
  input  ccte_pkg::entry_t     nbr_i,
  input  ccte_pkg::entry_t     feed_i,
  input  ccte_pkg::entry_t     load_data_i,
  output ccte_pkg::entry_t     entry_o
);
  import ccte_pkg::*;

  entry_t entry_q;
  entry_t entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.load) begin
      entry_d = load_data_i;
    end else if (ctrl_i.shift && ctrl_i.ring) begin
      // the last live slot closes the ring with the head entry
      entry_d = ctrl_i.tail ? feed_i : nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
